FILE: src/bdlp_pkg.sv
// Shared types and constants for the key debouncer with long-press detection.
`timescale 1ns / 1ps
`default_nettype none

package bdlp_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int DEB_WIDTH   = 16;
    localparam int LONG_WIDTH  = 16;
    localparam int KEY_WIDTH   = 10;
    localparam int CFG_IDX_WIDTH  = 2;
    localparam int CFG_DATA_WIDTH = 16;
    localparam int CMP_WIDTH = (COUNT_WIDTH > LONG_WIDTH) ? COUNT_WIDTH : LONG_WIDTH;

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_DEBOUNCE_TICKS   = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_LONG_PRESS_TICKS = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_KEY_ID           = 2'd2;

    localparam logic [DEB_WIDTH-1:0]  DEBOUNCE_RESET = 16'd20;
    localparam logic [LONG_WIDTH-1:0] LONG_RESET     = 16'd500;
    localparam logic [KEY_WIDTH-1:0]  KEY_RESET      = 10'd0;

    typedef struct packed {
        logic [DEB_WIDTH-1:0]  debounce_ticks;
        logic [LONG_WIDTH-1:0] long_press_ticks;
        logic [KEY_WIDTH-1:0]  key_id;
    } cfg_t;

endpackage

`default_nettype wire

FILE: src/button_debounce_long_press.sv
// Top level of the single-key debouncer with long-press detection.
//
// Usage:
//   Feed one transaction per millisecond tick on the s_ channel; s_tdata[0]
//   is the raw key level (0 pressed, 1 released). Any level change reloads
//   the debounce countdown; when it runs out the level is sampled. A sampled
//   press clears the elapsed counter, a sampled release emits one event on
//   the m_ channel with the key id and a quick/long flag.
//   Configuration writes on the cfg_ channel are always taken (cfg_ready is
//   tied high): index 0 debounce ticks, 1 long-press ticks, 2 key id; other
//   indexes are ignored. Write only while the block is idle.
// Timing and throughput:
//   The state update is done in the cycle a tick is accepted; an event shows
//   on m_tvalid in the next cycle. One tick per cycle is taken while the
//   output register is empty or being drained.
// Reset:
//   aresetn low clears the level to released, the countdown to idle and the
//   elapsed counter to saturated, and restores the register defaults.
// Stall:
//   While m_tready is low with an event pending, s_tready drops and the event
//   holds until taken.
`timescale 1ns / 1ps
`default_nettype none

module button_debounce_long_press (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [7:0]                          s_tdata,   // [0] raw_level
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [15:0]                              m_tdata,   // [9:0] event_key, [10] is_long_press
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [bdlp_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
    input  wire logic [bdlp_pkg::CFG_DATA_WIDTH-1:0] cfg_data
);

    localparam int CW = bdlp_pkg::COUNT_WIDTH;
    localparam int DW = bdlp_pkg::DEB_WIDTH;
    localparam int KW = bdlp_pkg::KEY_WIDTH;
    localparam int MW = bdlp_pkg::CMP_WIDTH;
    localparam logic [CW-1:0] ELAPSED_MAX = {CW{1'b1}};

    bdlp_pkg::cfg_t cfg;

    logic          level_reg,    level_next;
    logic [DW-1:0] deb_left_reg, deb_left_next;
    logic [CW-1:0] elapsed_reg,  elapsed_next;
    logic          out_valid_reg, out_valid_next;
    logic [KW-1:0] out_key_reg,  out_key_next;
    logic          out_long_reg, out_long_next;

    logic          level_in;
    logic          accept;
    logic [CW-1:0] elapsed_inc;
    logic [DW-1:0] deb_dec;
    logic          emit;
    logic          is_long;

    bdlp_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign level_in = s_tdata[0];

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_long_reg, out_key_reg};

    always_comb begin
        elapsed_inc = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg : elapsed_reg + 1'b1;
        deb_dec     = deb_left_reg - 1'b1;
        is_long     = (MW'(elapsed_inc) >= MW'(cfg.long_press_ticks))
                      || (elapsed_inc == ELAPSED_MAX);

        level_next     = level_reg;
        deb_left_next  = deb_left_reg;
        elapsed_next   = elapsed_reg;
        emit           = 1'b0;

        if (accept) begin
            elapsed_next = elapsed_inc;
            if (level_in != level_reg) begin
                level_next    = level_in;
                deb_left_next = (cfg.debounce_ticks == '0) ? DW'(1) : cfg.debounce_ticks;
            end else if (deb_left_reg != '0) begin
                deb_left_next = deb_dec;
                if (deb_dec == '0) begin
                    if (!level_in) begin
                        elapsed_next = '0;
                    end else begin
                        emit = 1'b1;
                    end
                end
            end
        end

        out_valid_next = out_valid_reg;
        out_key_next   = out_key_reg;
        out_long_next  = out_long_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (emit) begin
            out_valid_next = 1'b1;
            out_key_next   = cfg.key_id;
            out_long_next  = is_long;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg     <= 1'b1;
            deb_left_reg  <= '0;
            elapsed_reg   <= ELAPSED_MAX;
            out_valid_reg <= 1'b0;
        end else begin
            level_reg     <= level_next;
            deb_left_reg  <= deb_left_next;
            elapsed_reg   <= elapsed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_key_reg  <= out_key_next;
        out_long_reg <= out_long_next;
    end

endmodule

`default_nettype wire

FILE: src/bdlp_cfg_regs.sv
// Configuration register file for the key debouncer.
`timescale 1ns / 1ps
`default_nettype none

module bdlp_cfg_regs (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [bdlp_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
    input  wire logic [bdlp_pkg::CFG_DATA_WIDTH-1:0] cfg_data,
    output bdlp_pkg::cfg_t                           cfg
);

    bdlp_pkg::cfg_t cfg_reg;
    bdlp_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                bdlp_pkg::CFG_DEBOUNCE_TICKS: begin
                    cfg_next.debounce_ticks = cfg_data[bdlp_pkg::DEB_WIDTH-1:0];
                end
                bdlp_pkg::CFG_LONG_PRESS_TICKS: begin
                    cfg_next.long_press_ticks = cfg_data[bdlp_pkg::LONG_WIDTH-1:0];
                end
                bdlp_pkg::CFG_KEY_ID: begin
                    cfg_next.key_id = cfg_data[bdlp_pkg::KEY_WIDTH-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ticks   <= bdlp_pkg::DEBOUNCE_RESET;
            cfg_reg.long_press_ticks <= bdlp_pkg::LONG_RESET;
            cfg_reg.key_id           <= bdlp_pkg::KEY_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

FILE: verif/bdlp_release_monitor.sv
// Monitor that predicts key release events from observed ticks and compares them.
`timescale 1ns / 1ps

module bdlp_release_monitor
    import bdlp_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [7:0]                s_tdata,   // [0] raw_level
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [15:0]               m_tdata,   // [9:0] event_key, [10] is_long_press
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [CFG_IDX_WIDTH-1:0]  cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0] cfg_data,
    output int                        fail_count,
    output int                        events_due_count
);

    typedef struct packed {
        logic [KEY_WIDTH-1:0] key;
        logic                 is_long;
    } key_event_t;

    cfg_t                   key_cfg;
    logic                   level_q;
    logic [DEB_WIDTH-1:0]   settle_left;
    logic [COUNT_WIDTH-1:0] held_ticks;
    key_event_t             events_due[$];
    key_event_t             oldest_due;

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $time, what);
        fail_count++;
    endtask

    task automatic apply_reg_write(input logic [CFG_IDX_WIDTH-1:0] idx,
                                   input logic [CFG_DATA_WIDTH-1:0] val);
        case (idx)
            CFG_DEBOUNCE_TICKS: begin
                key_cfg.debounce_ticks = val[DEB_WIDTH-1:0];
            end
            CFG_LONG_PRESS_TICKS: begin
                key_cfg.long_press_ticks = val[LONG_WIDTH-1:0];
            end
            CFG_KEY_ID: begin
                key_cfg.key_id = val[KEY_WIDTH-1:0];
            end
            default: begin
            end
        endcase
    endtask

    task automatic advance_key_tick(input logic lvl);
        key_event_t ev;
        if (held_ticks != '1)
            held_ticks++;
        if (lvl != level_q) begin
            level_q = lvl;
            settle_left = (key_cfg.debounce_ticks == '0) ? DEB_WIDTH'(1) : key_cfg.debounce_ticks;
        end else if (settle_left != '0) begin
            settle_left--;
            if (settle_left == '0) begin
                if (!lvl) begin
                    held_ticks = '0;
                end else begin
                    ev.key     = key_cfg.key_id;
                    ev.is_long = (CMP_WIDTH'(held_ticks) >= CMP_WIDTH'(key_cfg.long_press_ticks))
                                 || (held_ticks == '1);
                    events_due.push_back(ev);
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            key_cfg     = '{DEBOUNCE_RESET, LONG_RESET, KEY_RESET};
            level_q     = 1'b1;
            settle_left = '0;
            held_ticks  = '1;
            fail_count  = 0;
            events_due.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                apply_reg_write(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                advance_key_tick(s_tdata[0]);
            if (m_tvalid && m_tready) begin
                if (events_due.size() == 0) begin
                    report_mismatch($sformatf("event key %0d long %0b with none predicted",
                                              m_tdata[KEY_WIDTH-1:0], m_tdata[KEY_WIDTH]));
                end else begin
                    oldest_due = events_due.pop_front();
                    if (m_tdata[KEY_WIDTH-1:0] != oldest_due.key)
                        report_mismatch($sformatf("event_key %0d, predicted %0d",
                                                  m_tdata[KEY_WIDTH-1:0], oldest_due.key));
                    if (m_tdata[KEY_WIDTH] != oldest_due.is_long)
                        report_mismatch($sformatf("is_long_press %0b, predicted %0b",
                                                  m_tdata[KEY_WIDTH], oldest_due.is_long));
                end
            end
        end
        events_due_count = events_due.size();
    end

endmodule

FILE: verif/tb_button_debounce_long_press.sv
// Testbench top: drives key ticks and register writes, and gives the verdict.
`timescale 1ns / 1ps

module tb_button_debounce_long_press;
    import bdlp_pkg::*;

    localparam int TICK_TARGET     = 1350;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_CYCLES    = 20;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_UNUSED_INDEX = 2'd3;
    localparam logic [0:18] DIRECTED_LEVELS = 19'b011_0011_00011_000011_1;

    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [7:0]                s_tdata   = '0;   // [0] raw_level
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [15:0]               m_tdata;          // [9:0] event_key, [10] is_long_press
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_WIDTH-1:0]  cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0] cfg_data  = '0;

    int   fail_count;
    int   events_due_count;
    int   cycle_count  = 0;
    int   ticks_sent   = 0;
    int   s_idle_pct   = 0;
    int   rx_idle_pct  = 0;
    int   cur_deb      = 20;
    int   cur_long     = 500;
    logic rx_hold      = 1'b0;
    logic hold_req     = 1'b0;

    button_debounce_long_press uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bdlp_release_monitor release_monitor (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .fail_count       (fail_count),
        .events_due_count (events_due_count)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("button_debounce_long_press verification failed");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end

    initial begin
        wait (hold_req);
        @(posedge aclk);
        rx_hold = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge aclk);
        rx_hold = 1'b0;
    end

    task automatic send_tick(input logic lvl);
        while ($urandom_range(99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, lvl};
        do @(posedge aclk); while (!s_tready);
        ticks_sent++;
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        wait (events_due_count == 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic send_bounce(input logic first_lvl);
        int n;
        n = $urandom_range(0, 3);
        repeat (n) begin
            send_tick(first_lvl);
            send_tick(!first_lvl);
        end
    endtask

    // One press and release with contact bounce, or a burst of noise.
    task automatic press_cycle();
        int settle;
        int held;
        settle = (cur_deb == 0) ? 1 : cur_deb;
        held   = (cur_long <= 64) ? $urandom_range(0, 2 * cur_long + 2) : $urandom_range(0, 60);
        if ($urandom_range(99) < 20) begin
            repeat ($urandom_range(1, 10)) send_tick(1'($urandom_range(0, 1)));
            return;
        end
        send_bounce(1'b0);
        repeat (settle + held) send_tick(1'b0);
        send_bounce(1'b1);
        repeat (settle + $urandom_range(0, 4)) send_tick(1'b1);
    endtask

    initial begin
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        s_idle_pct  = 9;
        rx_idle_pct = 60;
        write_reg(CFG_DEBOUNCE_TICKS, 16'd0);
        write_reg(CFG_LONG_PRESS_TICKS, 16'd3);
        write_reg(CFG_KEY_ID, 16'hFFFF);
        write_reg(CFG_UNUSED_INDEX, 16'hFFFF);
        cur_deb  = 0;
        cur_long = 3;
        for (int i = 0; i <= 18; i++)
            send_tick(DIRECTED_LEVELS[i]);

        wait_idle();
        cur_deb  = $urandom_range(1, 6);
        cur_long = $urandom_range(2, 30);
        write_reg(CFG_DEBOUNCE_TICKS, 16'(cur_deb));
        write_reg(CFG_LONG_PRESS_TICKS, 16'(cur_long));
        write_reg(CFG_KEY_ID, 16'($urandom_range(0, 1023)));
        while (ticks_sent < 470)
            press_cycle();

        wait_idle();
        s_idle_pct  = 60;
        rx_idle_pct = 9;
        cur_deb  = 1;
        cur_long = 0;
        write_reg(CFG_DEBOUNCE_TICKS, 16'(cur_deb));
        write_reg(CFG_LONG_PRESS_TICKS, 16'(cur_long));
        write_reg(CFG_KEY_ID, 16'd0);
        while (ticks_sent < 920)
            press_cycle();

        // countdown never expires at the largest setting
        wait_idle();
        cur_deb  = 65535;
        cur_long = 1;
        write_reg(CFG_DEBOUNCE_TICKS, 16'(cur_deb));
        write_reg(CFG_LONG_PRESS_TICKS, 16'(cur_long));
        write_reg(CFG_KEY_ID, 16'($urandom_range(0, 1023)));
        repeat (40) send_tick(1'($urandom_range(0, 1)));

        wait_idle();
        s_idle_pct  = 0;
        rx_idle_pct = 0;
        cur_deb  = $urandom_range(2, 8);
        cur_long = 65535;
        write_reg(CFG_DEBOUNCE_TICKS, 16'(cur_deb));
        write_reg(CFG_LONG_PRESS_TICKS, 16'(cur_long));
        write_reg(CFG_KEY_ID, 16'($urandom_range(0, 1023)));
        while (ticks_sent < TICK_TARGET) begin
            if (ticks_sent >= 1040)
                hold_req = 1'b1;
            press_cycle();
        end

        s_tvalid <= 1'b0;
        wait (events_due_count == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && events_due_count == 0) begin
            $display("button_debounce_long_press verification clean");
        end else begin
            $display("button_debounce_long_press verification failed");
        end
        $finish;
    end

endmodule
